FILE: src/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg: shared types, constants and microcode for the tone-stack equalizer
// Holds the Q8.24 constants, the control word that the sequencer hands to
// the datapath, and the program that computes one sample.
// ----------------------------------------------------------------------------
package teq_pkg;

    // Widths of the arithmetic.
    localparam int WORD_W         = 32;
    localparam int COEF_W         = 25;
    localparam int MUL_B_W        = WORD_W + 1;
    localparam int PROD_W         = WORD_W + MUL_B_W;
    localparam int Q_FRAC         = 24;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed filter coefficients and register reset values.
    localparam logic [COEF_W-1:0] RUMBLE_COEF  = 25'h002FF8C;
    localparam logic [COEF_W-1:0] BASS_COEF    = 25'h003FD65;
    localparam logic [COEF_W-1:0] TREBLE_COEF  = 25'h0579B7C;
    localparam logic [COEF_W-1:0] MID_COEF_RST = 25'h013563F;
    localparam logic [COEF_W-1:0] LP_COEF_RST  = 25'h092ACAE;
    localparam logic signed [WORD_W-1:0] UNITY_Q24 = 32'sh01000000;

    // Output clamp limits.
    localparam logic signed [WORD_W-1:0] PEAK_POS = 32'sh7FFFFF00;
    localparam logic signed [WORD_W-1:0] PEAK_NEG = -32'sh7FFFFF00;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_INPUT_GAIN  = 3'd0,
        CFG_OUT_VOLUME  = 3'd1,
        CFG_BASS_GAIN   = 3'd2,
        CFG_MID_GAIN    = 3'd3,
        CFG_MID_COEF    = 3'd4,
        CFG_TREBLE_GAIN = 3'd5,
        CFG_LP_COEF     = 3'd6
    } cfg_idx_t;

    // Filter state registers.
    localparam int ST_N = 6;
    typedef enum logic [2:0] {
        ST_RUMBLE = 3'd0,
        ST_GLOBAL = 3'd1,
        ST_BASS   = 3'd2,
        ST_MID_HP = 3'd3,
        ST_MID_LP = 3'd4,
        ST_TREBLE = 3'd5
    } st_sel_t;

    // Multiplier operand A source.
    typedef enum logic [1:0] {
        MA_X,
        MA_D,
        MA_SUM,
        MA_ST
    } mul_a_t;

    // Multiplier operand B source.
    typedef enum logic [3:0] {
        MB_IN_GAIN,
        MB_RUMBLE,
        MB_LP_COEF,
        MB_BASS,
        MB_BASS_GAIN,
        MB_MID_COEF,
        MB_MID_GAIN,
        MB_TREBLE,
        MB_TREBLE_GAIN,
        MB_VOLUME
    } mul_b_t;

    // Difference register operation (st means the selected state register,
    // new means that state plus the product register).
    typedef enum logic [2:0] {
        D_NONE,
        D_P_MINUS_ST,
        D_X_MINUS_ST,
        D_H_MINUS_ST,
        D_X_MINUS_NEW
    } d_op_t;

    // Signal register operation.
    typedef enum logic [2:0] {
        X_NONE,
        X_LOAD_IN,
        X_P,
        X_X_MINUS_NEW,
        X_NEW
    } x_op_t;

    // Band sum operation.
    typedef enum logic [1:0] {
        S_NONE,
        S_LOAD,
        S_ADD
    } sum_op_t;

    // Sequencer jump condition.
    typedef enum logic [1:0] {
        J_NEXT,
        J_WAIT_IN,
        J_WAIT_OUT_RET
    } jmp_t;

    // One control word of the program.
    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        logic    mul_en;
        st_sel_t st_sel;
        logic    st_we;
        d_op_t   d_op;
        x_op_t   x_op;
        logic    h_we;
        sum_op_t sum_op;
        logic    out_load;
        jmp_t    jmp;
    } ctrl_t;

    localparam int UC_LEN    = 26;
    localparam int UC_STEP_W = $clog2(UC_LEN);

    localparam ctrl_t CTRL_NOP = '{
        mul_a:    MA_X,
        mul_b:    MB_IN_GAIN,
        mul_en:   1'b0,
        st_sel:   ST_RUMBLE,
        st_we:    1'b0,
        d_op:     D_NONE,
        x_op:     X_NONE,
        h_we:     1'b0,
        sum_op:   S_NONE,
        out_load: 1'b0,
        jmp:      J_NEXT
    };

    // Program for one sample. Every product lands in the product register
    // at the end of its step, so the step that consumes it comes next.
    function automatic ctrl_t ucode(input logic [UC_STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        case (step)
            // Idle: take a word into the signal register.
            5'd0:
            begin
                w.x_op = X_LOAD_IN;
                w.jmp  = J_WAIT_IN;
            end
            // Input gain.
            5'd1:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_X; w.mul_b = MB_IN_GAIN;
            end
            5'd2:
            begin
                w.x_op = X_P; w.d_op = D_P_MINUS_ST; w.st_sel = ST_RUMBLE;
            end
            // Rumble high-pass.
            5'd3:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_RUMBLE;
            end
            5'd4:
            begin
                w.st_sel = ST_RUMBLE; w.st_we = 1'b1; w.x_op = X_X_MINUS_NEW;
            end
            // Global low-pass.
            5'd5:
            begin
                w.st_sel = ST_GLOBAL; w.d_op = D_X_MINUS_ST;
            end
            5'd6:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_LP_COEF;
            end
            5'd7:
            begin
                w.st_sel = ST_GLOBAL; w.st_we = 1'b1; w.x_op = X_NEW;
            end
            // Bass low-pass and bass gain.
            5'd8:
            begin
                w.st_sel = ST_BASS; w.d_op = D_X_MINUS_ST;
            end
            5'd9:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_BASS;
            end
            5'd10:
            begin
                w.st_sel = ST_BASS; w.st_we = 1'b1;
            end
            5'd11:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_ST; w.mul_b = MB_BASS_GAIN;
                w.st_sel = ST_BASS;
            end
            // Mid high-pass.
            5'd12:
            begin
                w.sum_op = S_LOAD; w.st_sel = ST_MID_HP; w.d_op = D_X_MINUS_ST;
            end
            5'd13:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_MID_COEF;
            end
            5'd14:
            begin
                w.st_sel = ST_MID_HP; w.st_we = 1'b1; w.h_we = 1'b1;
            end
            // Mid low-pass and mid gain.
            5'd15:
            begin
                w.st_sel = ST_MID_LP; w.d_op = D_H_MINUS_ST;
            end
            5'd16:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_MID_COEF;
            end
            5'd17:
            begin
                w.st_sel = ST_MID_LP; w.st_we = 1'b1;
            end
            5'd18:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_ST; w.mul_b = MB_MID_GAIN;
                w.st_sel = ST_MID_LP;
            end
            // Treble high-shelf and treble gain.
            5'd19:
            begin
                w.sum_op = S_ADD; w.st_sel = ST_TREBLE; w.d_op = D_X_MINUS_ST;
            end
            5'd20:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_TREBLE;
            end
            5'd21:
            begin
                w.st_sel = ST_TREBLE; w.st_we = 1'b1; w.d_op = D_X_MINUS_NEW;
            end
            5'd22:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_D; w.mul_b = MB_TREBLE_GAIN;
            end
            // Mix, volume and output.
            5'd23:
            begin
                w.sum_op = S_ADD;
            end
            5'd24:
            begin
                w.mul_en = 1'b1; w.mul_a = MA_SUM; w.mul_b = MB_VOLUME;
            end
            5'd25:
            begin
                w.out_load = 1'b1; w.jmp = J_WAIT_OUT_RET;
            end
            default:
            begin
                w.jmp = J_WAIT_OUT_RET;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: src/three_band_tonestack_eq_core.sv
// ----------------------------------------------------------------------------
// three_band_tonestack_eq_core: three-band tone-stack equalizer, one channel
// Each input word is one signed sample; it is taken at the idle step of the
// program, and its result enters the output register at the output step.
// A new word is accepted only once the previous one has reached that register.
// The pace is set by the eleven dependent Q8.24 products that go one after
// another through the single shared 32 x 33 multiplier under control of the
// microcode program. The result register holds a finished word while the next
// sample is processed.
// The user must write settings through the plain write port only while the
// block is idle; the block does not enforce this. Gains are signed Q8.24,
// coefficients unsigned 25-bit Q1.24; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module three_band_tonestack_eq_core
    import teq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [WORD_W-1:0]            cfg_data,
    input  logic signed [DATA_WIDTH-1:0] sample_in,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic signed [WORD_W-1:0]     sample_out,
    output logic                         out_valid,
    input  logic                         out_stall
);

    ctrl_t ctrl;
    logic  out_free;

    // Sequencer.
    teq_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Datapath.
    teq_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .out_valid  (out_valid),
        .out_free   (out_free)
    );

    // Input words are taken only at the idle step of the program.
    assign in_stall = (ctrl.jmp != J_WAIT_IN);

`ifndef NO_ASSERTIONS
    // A word accepted starts the program, so the next cycle is busy.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input accepted on consecutive cycles");

    // A result appears only after the output step of the program.
    a_out_from_program: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.out_load)
    ) else $error("output valid without an output step");

    // Every delivered word lies within the clamp limits.
    a_out_clamped: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_out <= PEAK_POS && sample_out >= PEAK_NEG)
    ) else $error("output word outside clamp limits");
`endif

endmodule

FILE: src/teq_useq.sv
// ----------------------------------------------------------------------------
// teq_useq: microcode sequencer
// A step counter addresses the program table; each control word carries a
// jump condition that holds the counter while waiting for an input word or
// for room in the output register.
// ----------------------------------------------------------------------------
module teq_useq
    import teq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_free,
    output ctrl_t ctrl
);

    logic [UC_STEP_W-1:0] step_reg;
    logic [UC_STEP_W-1:0] step_next;

    // Program table lookup.
    assign ctrl = ucode(step_reg);

    // Next step from the jump condition.
    always_comb
    begin
        case (ctrl.jmp)
            J_NEXT:
            begin
                step_next = step_reg + UC_STEP_W'(1);
            end
            J_WAIT_IN:
            begin
                step_next = in_valid ? step_reg + UC_STEP_W'(1) : step_reg;
            end
            J_WAIT_OUT_RET:
            begin
                step_next = out_free ? '0 : step_reg;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: src/teq_dpath.sv
// ----------------------------------------------------------------------------
// teq_dpath: equalizer datapath
// One shared Q8.24 multiplier with a product register, the filter state
// registers, working registers for the signal and band sum, the setting
// registers and the output register, all steered by the control word.
// ----------------------------------------------------------------------------
module teq_dpath
    import teq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctrl_t                        ctrl,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [WORD_W-1:0]            cfg_data,
    input  logic signed [DATA_WIDTH-1:0] sample_in,
    input  logic                         out_stall,
    output logic signed [WORD_W-1:0]     sample_out,
    output logic                         out_valid,
    output logic                         out_free
);

    // Setting registers.
    logic signed [WORD_W-1:0] in_gain_reg;
    logic signed [WORD_W-1:0] volume_reg;
    logic signed [WORD_W-1:0] bass_gain_reg;
    logic signed [WORD_W-1:0] mid_gain_reg;
    logic signed [WORD_W-1:0] treble_gain_reg;
    logic [COEF_W-1:0]        mid_coef_reg;
    logic [COEF_W-1:0]        lp_coef_reg;

    // Working registers.
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] d_reg;
    logic signed [WORD_W-1:0] h_reg;
    logic signed [WORD_W-1:0] sum_reg;
    logic signed [WORD_W-1:0] p_reg;
    logic signed [WORD_W-1:0] st_reg [ST_N];
    logic signed [WORD_W-1:0] out_reg;
    logic                     out_valid_reg;

    logic signed [WORD_W-1:0]  st_rd;
    logic signed [WORD_W-1:0]  st_new;
    logic signed [WORD_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [WORD_W-1:0]  clamped;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gain_reg     <= UNITY_Q24;
            volume_reg      <= UNITY_Q24;
            bass_gain_reg   <= UNITY_Q24;
            mid_gain_reg    <= UNITY_Q24;
            treble_gain_reg <= UNITY_Q24;
            mid_coef_reg    <= MID_COEF_RST;
            lp_coef_reg     <= LP_COEF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INPUT_GAIN:  in_gain_reg     <= cfg_data;
                CFG_OUT_VOLUME:  volume_reg      <= cfg_data;
                CFG_BASS_GAIN:   bass_gain_reg   <= cfg_data;
                CFG_MID_GAIN:    mid_gain_reg    <= cfg_data;
                CFG_MID_COEF:    mid_coef_reg    <= cfg_data[COEF_W-1:0];
                CFG_TREBLE_GAIN: treble_gain_reg <= cfg_data;
                CFG_LP_COEF:     lp_coef_reg     <= cfg_data[COEF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Selected state register and its updated value.
    always_comb
    begin
        case (ctrl.st_sel)
            ST_RUMBLE: st_rd = st_reg[ST_RUMBLE];
            ST_GLOBAL: st_rd = st_reg[ST_GLOBAL];
            ST_BASS:   st_rd = st_reg[ST_BASS];
            ST_MID_HP: st_rd = st_reg[ST_MID_HP];
            ST_MID_LP: st_rd = st_reg[ST_MID_LP];
            ST_TREBLE: st_rd = st_reg[ST_TREBLE];
            default:   st_rd = '0;
        endcase
    end

    assign st_new = st_rd + p_reg;

    // Multiplier operand A.
    always_comb
    begin
        case (ctrl.mul_a)
            MA_X:    mul_a = x_reg;
            MA_D:    mul_a = d_reg;
            MA_SUM:  mul_a = sum_reg;
            MA_ST:   mul_a = st_rd;
            default: mul_a = x_reg;
        endcase
    end

    // Multiplier operand B: gains sign-extend, coefficients zero-extend.
    always_comb
    begin
        case (ctrl.mul_b)
            MB_IN_GAIN:     mul_b = MUL_B_W'(in_gain_reg);
            MB_RUMBLE:      mul_b = MUL_B_W'(signed'({1'b0, RUMBLE_COEF}));
            MB_LP_COEF:     mul_b = MUL_B_W'(signed'({1'b0, lp_coef_reg}));
            MB_BASS:        mul_b = MUL_B_W'(signed'({1'b0, BASS_COEF}));
            MB_BASS_GAIN:   mul_b = MUL_B_W'(bass_gain_reg);
            MB_MID_COEF:    mul_b = MUL_B_W'(signed'({1'b0, mid_coef_reg}));
            MB_MID_GAIN:    mul_b = MUL_B_W'(mid_gain_reg);
            MB_TREBLE:      mul_b = MUL_B_W'(signed'({1'b0, TREBLE_COEF}));
            MB_TREBLE_GAIN: mul_b = MUL_B_W'(treble_gain_reg);
            MB_VOLUME:      mul_b = MUL_B_W'(volume_reg);
            default:        mul_b = '0;
        endcase
    end

    // Full signed product; the Q8.24 result is its middle word.
    assign prod = mul_a * mul_b;

    // Product, signal, difference, mid high-pass and sum registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_reg <= prod[Q_FRAC+WORD_W-1 -: WORD_W];
        end

        case (ctrl.x_op)
            X_LOAD_IN:     x_reg <= WORD_W'(sample_in);
            X_P:           x_reg <= p_reg;
            X_X_MINUS_NEW: x_reg <= x_reg - st_new;
            X_NEW:         x_reg <= st_new;
            default:
            begin
            end
        endcase

        case (ctrl.d_op)
            D_P_MINUS_ST:  d_reg <= p_reg - st_rd;
            D_X_MINUS_ST:  d_reg <= x_reg - st_rd;
            D_H_MINUS_ST:  d_reg <= h_reg - st_rd;
            D_X_MINUS_NEW: d_reg <= x_reg - st_new;
            default:
            begin
            end
        endcase

        if (ctrl.h_we)
        begin
            h_reg <= x_reg - st_new;
        end

        case (ctrl.sum_op)
            S_LOAD: sum_reg <= p_reg;
            S_ADD:  sum_reg <= sum_reg + p_reg;
            default:
            begin
            end
        endcase
    end

    // Filter state accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ST_N; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (ctrl.st_we)
        begin
            st_reg[ctrl.st_sel] <= st_new;
        end
    end

    // Output clamp.
    always_comb
    begin
        if (p_reg > PEAK_POS)
        begin
            clamped = PEAK_POS;
        end
        else if (p_reg < PEAK_NEG)
        begin
            clamped = PEAK_NEG;
        end
        else
        begin
            clamped = p_reg;
        end
    end

    // Output register; it takes a new word when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load && out_free)
        begin
            out_reg <= clamped;
        end
    end

    assign sample_out = out_reg;
    assign out_valid  = out_valid_reg;

endmodule
